FILE: hdl/awa_pkg.sv
// Shared types, constants and helpers for the automaton word acceptor.
package awa_pkg;

	localparam int ARC_COUNT  = 4096;
	localparam int LABEL_BITS = 8;

	localparam int IDX_W  = 12;
	localparam int LTR_W  = 8;
	localparam int LBL_W  = (LABEL_BITS < LTR_W) ? LABEL_BITS : LTR_W;
	localparam int ADDR_W = $clog2(ARC_COUNT);

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LETTER = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic             op;
		idx_t             arc_addr;
		logic [LTR_W-1:0] arc_label;
		idx_t             arc_target;
		logic             arc_final;
		logic             arc_last;
		logic [LTR_W-1:0] letter;
		logic             word_end;
	} item_t;

	typedef struct packed {
		logic prefix_alive;
		logic accepted;
		logic word_done;
		idx_t arc_used;
	} result_t;

	typedef struct packed {
		logic [LBL_W-1:0] label;
		idx_t             target;
		logic             is_final;
		logic             is_last;
	} arc_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Index 0 is the no-transition sentinel; indexes past the table miss.
	function automatic logic idx_ok(input idx_t x);
		return (x != '0) && (32'(x) < ARC_COUNT);
	endfunction

endpackage

FILE: hdl/automaton_word_acceptor.sv
// Top level: arc-table automaton that checks words one letter beat at a time.
// Write beat: gives no result; the next beat is taken next cycle. Letter beat: IDLE reads
// the node's first arc, SCAN checks one arc per cycle on the arc memory's single read port
// until a match or the node ends (a failed word or sentinel node skips SCAN), DONE registers
// the result; the next beat is taken the cycle after. A stalled result holds the block until
// it drains. Reset clears control state, start_node returns to 1; the arc memory is not cleared;
// the user must read an entry only after it was written, which the block does not enforce.
module automaton_word_acceptor (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  awa_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_stall,
	output awa_pkg::result_t result,
	input  logic            cfg_we,
	input  awa_pkg::idx_t   cfg_wdata
);
	import awa_pkg::*;

	// Arc memory: one write port (load beats), one registered read port (scan).
	arc_entry_t mem [ARC_COUNT];
	arc_entry_t rd_data_s1;

	// Control state
	state_t state_q, state_d;
	idx_t   start_q;       // first arc of the start node
	idx_t   cur_q;         // node reached by the word so far
	logic   in_word_q;     // a word is in progress
	logic   failed_q;      // some letter of this word found no arc

	// Letter being scanned
	logic [LBL_W-1:0] lbl_q;
	logic             end_q;
	idx_t             idx_q;  // arc index of the entry held in rd_data_s1

	// Finished result waiting for the output register
	logic res_alive_q;
	logic res_acc_q;
	idx_t res_used_q;

	// Output register
	logic    result_valid_q;
	result_t result_q;

	// Decode
	logic       accept, wr_acc, let_acc;
	idx_t       node_eff;
	logic       fail_eff, first_ok;
	logic       rd_en;
	idx_t       rd_addr;
	logic       hit, step, load;
	logic [IDX_W:0] nxt;

	assign accept   = item_valid && !item_stall;
	assign wr_acc   = accept && (item.op == OP_WRITE);
	assign let_acc  = accept && (item.op == OP_LETTER);
	// First letter of a word restarts at start_node with a clean slate.
	assign node_eff = in_word_q ? cur_q : start_q;
	assign fail_eff = in_word_q && failed_q;
	assign first_ok = idx_ok(node_eff);
	assign nxt      = {1'b0, idx_q} + {{IDX_W{1'b0}}, 1'b1};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (let_acc) begin
					state_d = (!fail_eff && first_ok) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				state_d = step ? ST_SCAN : ST_DONE;
			end
			ST_DONE: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		item_stall = 1'b1;
		rd_en      = 1'b0;
		rd_addr    = node_eff;
		hit        = 1'b0;
		step       = 1'b0;
		load       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				rd_en      = let_acc && !fail_eff && first_ok;
				rd_addr    = node_eff;
			end
			ST_SCAN: begin
				// Label match wins; otherwise move on unless the node or table ends.
				hit     = (rd_data_s1.label == lbl_q);
				step    = !hit && !rd_data_s1.is_last && !nxt[IDX_W] && idx_ok(nxt[IDX_W-1:0]);
				rd_en   = step;
				rd_addr = nxt[IDX_W-1:0];
			end
			ST_DONE: begin
				load = !result_valid_q || !result_stall;
			end
			default: item_stall = 1'b1;
		endcase
	end

	// Arc memory
	always_ff @(posedge clk) begin
		if (wr_acc && (32'(item.arc_addr) < ARC_COUNT)) begin
			mem[ADDR_W'(item.arc_addr)] <= '{
				label:    item.arc_label[LBL_W-1:0],
				target:   item.arc_target,
				is_final: item.arc_final,
				is_last:  item.arc_last
			};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[ADDR_W'(rd_addr)];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			start_q        <= idx_t'(1);
			cur_q          <= '0;
			in_word_q      <= 1'b0;
			failed_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
			if (let_acc) begin
				in_word_q <= 1'b1;
				failed_q  <= fail_eff || !first_ok;
				if (!in_word_q) begin
					cur_q <= start_q;
				end
			end
			if (state_q == ST_SCAN) begin
				if (hit) begin
					cur_q <= rd_data_s1.target;
				end else if (!step) begin
					failed_q <= 1'b1;
				end
			end
			if (load && end_q) begin
				in_word_q <= 1'b0;
			end
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Scan and result payload
	always_ff @(posedge clk) begin
		if (let_acc) begin
			lbl_q       <= item.letter[LBL_W-1:0];
			end_q       <= item.word_end;
			idx_q       <= node_eff;
			res_alive_q <= 1'b0;
			res_acc_q   <= 1'b0;
			res_used_q  <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (step) begin
				idx_q <= nxt[IDX_W-1:0];
			end
			if (hit) begin
				// Acceptance comes from the final flag of the arc just taken.
				res_alive_q <= 1'b1;
				res_acc_q   <= end_q && rd_data_s1.is_final;
				res_used_q  <= idx_q;
			end
		end
		if (load) begin
			result_q <= '{
				prefix_alive: res_alive_q,
				accepted:     res_acc_q,
				word_done:    end_q,
				arc_used:     res_used_q
			};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: hdl/awa_checker.sv
// Port-level checker for the automaton word acceptor, with its bind.
module awa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input awa_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input awa_pkg::result_t result
);
	import awa_pkg::*;

	// A stalled result beat stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// Acceptance only on a live word's last letter.
	a_accept_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.accepted |-> result.word_done && result.prefix_alive)
		else $error("accepted without live word end");

	// A live prefix always names the arc it took; a dead one names none.
	a_arc_used: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.arc_used != '0) == result.prefix_alive))
		else $error("arc_used disagrees with prefix_alive");

	// A letter beat occupies the block for at least the next cycle.
	a_letter_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.op == OP_LETTER) |=> item_stall)
		else $error("letter beat did not hold off the next beat");

endmodule

bind automaton_word_acceptor awa_checker u_awa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

FILE: verif/tb_automaton_word_acceptor.sv
// Self-checking testbench for the arc-table automaton word acceptor.
module tb_automaton_word_acceptor;
	import awa_pkg::*;

	// No-progress limit: a single scan may walk thousands of arcs and the receiver
	// holds off for hold_len in test_backpressure, so this leaves ample margin.
	localparam int STALL_LIMIT = 50000;
	localparam int RANDOM_BEATS = 1750;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	logic    cfg_we = 1'b0;
	idx_t    cfg_wdata = '0;

	automaton_word_acceptor u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the automaton: arc table plus the word-walk state.
	// arc_set marks entries that were loaded; the table is undefined until
	// then, so the stimulus never lets a scan touch an entry with it clear.
	// ------------------------------------------------------------------
	logic [LBL_W-1:0] arc_lbl [ARC_COUNT];
	idx_t             arc_tgt [ARC_COUNT];
	logic             arc_fin [ARC_COUNT];
	logic             arc_end [ARC_COUNT];
	logic             arc_set [ARC_COUNT];

	idx_t entry_node = idx_t'(1);   // start_node register, reset value 1
	idx_t at_node    = '0;
	idx_t prev_arc   = '0;
	logic word_dead  = 1'b0;
	logic mid_word   = 1'b0;

	result_t verdict_q [$];         // verdicts still owed by the block

	// Run statistics and error bookkeeping.
	int n_writes = 0, n_letters = 0, n_words = 0, n_hits = 0, n_dead = 0;
	int n_patch = 0, n_results = 0, err_count = 0;

	// Idling controls shared between the stimulus and the receiver.
	logic tx_quiet = 1'b0;
	logic rx_quiet = 1'b0;
	int   hold_req = 0;
	int   hold_len = 0;
	int   hold_served = 0;
	int   hold_left = 0;
	int   rx_run = 0;
	int   idle_cycles = 0;

	initial begin
		for (int i = 0; i < ARC_COUNT; i++)
			arc_set[i] = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Walk one node's arcs the way the block does. hit is the matching arc
	// (0 on a miss); hole is the first unloaded entry the walk would read.
	function automatic void walk_node(input int node, input logic [LBL_W-1:0] lbl,
			output int hit, output int hole);
		int idx;
		hit = 0;
		hole = 0;
		for (idx = node; idx <= 4096; idx++) begin
			// sentinel, or ran off the end of the table
			if (idx == 0 || idx > 4095 || idx >= ARC_COUNT)
				break;
			if (!arc_set[idx]) begin
				hole = idx;
				break;
			end
			if (arc_lbl[idx] == lbl) begin
				hit = idx;
				break;
			end
			if (arc_end[idx])
				break;
		end
	endfunction

	// Node that the next letter beat will scan.
	function automatic int scan_origin();
		return mid_word ? int'(at_node) : int'(entry_node);
	endfunction

	// Pick a label that exists on the node, so most words go deep.
	function automatic logic [LTR_W-1:0] pick_path_letter(input int node);
		logic [LTR_W-1:0] seen [$];
		int idx;
		idx = node;
		while (idx != 0 && idx < ARC_COUNT && arc_set[idx] && seen.size() < 16) begin
			seen = {seen, LTR_W'(arc_lbl[idx])};
			if (arc_end[idx])
				break;
			idx++;
		end
		if (seen.size() == 0)
			return LTR_W'($urandom);
		return seen[$urandom_range(0, seen.size() - 1)];
	endfunction

	// Update the shadow automaton with one accepted beat and queue the
	// verdict a letter beat must produce.
	task automatic predict_verdict(input item_t b);
		result_t v;
		int      hit, hole;
		v = '0;
		if (b.op == OP_WRITE) begin
			if (int'(b.arc_addr) < ARC_COUNT) begin
				arc_lbl[b.arc_addr] = b.arc_label[LBL_W-1:0];
				arc_tgt[b.arc_addr] = b.arc_target;
				arc_fin[b.arc_addr] = b.arc_final;
				arc_end[b.arc_addr] = b.arc_last;
				arc_set[b.arc_addr] = 1'b1;
			end
			n_writes++;
		end else begin
			n_letters++;
			// first letter of a word: start_node is sampled here
			if (!mid_word) begin
				at_node   = entry_node;
				word_dead = 1'b0;
				prev_arc  = '0;
				mid_word  = 1'b1;
			end
			// once dead, no scan and arc_used stays 0 until word end
			if (!word_dead) begin
				walk_node(int'(at_node), b.letter[LBL_W-1:0], hit, hole);
				if (hit == 0) begin
					word_dead = 1'b1;
				end else begin
					v.arc_used = idx_t'(hit);
					prev_arc   = idx_t'(hit);
					at_node    = arc_tgt[hit];
				end
			end
			if (b.word_end) begin
				v.accepted = !word_dead && prev_arc != '0 && int'(prev_arc) < ARC_COUNT
					&& arc_fin[prev_arc];
				mid_word = 1'b0;
				n_words++;
				if (v.accepted)
					n_hits++;
				if (word_dead)
					n_dead++;
			end
			v.prefix_alive = !word_dead;
			v.word_done    = b.word_end;
			verdict_q = {verdict_q, v};
		end
	endtask

	// Offer one beat, hold it until taken, then, unless tx_quiet, idle for a random gap.
	// Valid is only lowered for a gap, never in the step it is raised.
	task automatic send_beat(input item_t b);
		int n;
		item       <= b;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_verdict(b);
		n = tx_quiet ? 0 : pick_gap();
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Random filler in the unused fields keeps every input bit toggling.
	function automatic item_t random_beat();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(item_t)-1:0];
	endfunction

	task automatic send_arc(input int addr, input logic [LTR_W-1:0] lbl, input int tgt,
			input logic fin, input logic lst);
		item_t b;
		b            = random_beat();
		b.op         = OP_WRITE;
		b.arc_addr   = idx_t'(addr);
		b.arc_label  = lbl;
		b.arc_target = idx_t'(tgt);
		b.arc_final  = fin;
		b.arc_last   = lst;
		send_beat(b);
	endtask

	// Before a letter, load any entry its scan would read but that was never
	// written. Patches mostly close the node so walks stay short.
	task automatic send_letter(input logic [LTR_W-1:0] ltr, input logic last_ltr);
		item_t b;
		int    hit, hole;
		if (!(mid_word && word_dead)) begin
			walk_node(scan_origin(), ltr[LBL_W-1:0], hit, hole);
			while (hole != 0) begin
				send_arc(hole, LTR_W'($urandom), int'($urandom_range(0, 4095)),
					1'($urandom), $urandom_range(0, 3) != 0);
				n_patch++;
				walk_node(scan_origin(), ltr[LBL_W-1:0], hit, hole);
			end
		end
		b          = random_beat();
		b.op       = OP_LETTER;
		b.letter   = ltr;
		b.word_end = last_ltr;
		send_beat(b);
	endtask

	// A word of len letters, mostly along existing arcs, some random noise.
	task automatic send_word(input int len);
		logic [LTR_W-1:0] l;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 99) < 85)
				l = pick_path_letter(scan_origin());
			else
				l = LTR_W'($urandom);
			send_letter(l, k == len - 1);
		end
	endtask

	// Sender pauses until every owed verdict is back, then lets the block
	// settle (a write beat gives no result) before anything else happens.
	task automatic wait_quiet();
		item_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// start_node write; callers make sure the block is idle first.
	task automatic set_start_node(input int v);
		cfg_we    <= 1'b1;
		cfg_wdata <= idx_t'(v);
		@(posedge clk);
		cfg_we     <= 1'b0;
		entry_node  = idx_t'(v);
	endtask

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// Small dictionary at the reset start node: label extremes, final and
	// non-final last arcs, the sentinel target after a terminal arc, a miss,
	// letters after a miss, and a loop back to the start node.
	task automatic test_dictionary();
		send_arc(1, "a", 3, 1'b0, 1'b0);
		send_arc(2, "b", 0, 1'b1, 1'b1);
		send_arc(3, 8'hFF, 0, 1'b1, 1'b0);
		send_arc(4, 8'h00, 1, 1'b0, 1'b1);
		send_letter("a", 1'b0);  send_letter(8'hFF, 1'b1);   // accepted
		send_letter("a", 1'b0);  send_letter(8'h00, 1'b1);   // alive, not final
		send_letter("b", 1'b1);                              // one-letter word
		send_letter("a", 1'b0);  send_letter(8'hFF, 1'b0);
		send_letter("a", 1'b1);                              // scan at sentinel
		send_letter("x", 1'b0);  send_letter("b", 1'b1);     // dead word
		send_letter("a", 1'b0);  send_letter(8'h00, 1'b0);
		send_letter("b", 1'b1);                              // via loop back
	endtask

	// Top of the table: start node 4095, its only arc not marked last, so a
	// miss walks off the end of the table.
	task automatic test_table_end();
		wait_quiet();
		send_arc(4095, 8'h5A, 1, 1'b1, 1'b0);
		wait_quiet();
		set_start_node(4095);
		send_letter(8'h5A, 1'b1);
		send_letter(8'h5B, 1'b1);
	endtask

	// Start node set to the sentinel: every first letter misses.
	task automatic test_sentinel_start();
		wait_quiet();
		set_start_node(0);
		send_letter("a", 1'b1);
		wait_quiet();
		set_start_node(1);
	endtask

	// Receiver holds off a long stretch while letters keep coming, so the
	// block fills and stalls its input; then the sender waits it all out.
	task automatic test_backpressure();
		wait_quiet();
		tx_quiet = 1'b1;
		hold_len = 400;
		hold_req++;
		@(posedge clk);
		for (int w = 0; w < 12; w++)
			send_word($urandom_range(1, 5));
		tx_quiet = 1'b0;
		wait_quiet();
	endtask

	// Random automata at random places in the table, each followed by a
	// batch of words. Some rounds sit at the top of the table, some run
	// without idling on one or both sides.
	task automatic test_random_words();
		int goal, nodes, total, base, r, addr, tgt;
		int cnt [8];
		int node_at [8];
		logic near_end, lst;
		logic [LTR_W-1:0] lbl;
		goal = n_writes + n_letters + RANDOM_BEATS;
		while (n_writes + n_letters < goal) begin
			wait_quiet();
			tx_quiet = ($urandom_range(0, 5) == 0);
			rx_quiet = ($urandom_range(0, 5) == 0);
			nodes = $urandom_range(2, 8);
			total = 0;
			for (int i = 0; i < nodes; i++) begin
				cnt[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8)
					: $urandom_range(1, 4);
				total += cnt[i];
			end
			near_end = ($urandom_range(0, 5) == 0);
			base = near_end ? ARC_COUNT - total : $urandom_range(1, ARC_COUNT - 1 - total);
			node_at[0] = base;
			for (int i = 1; i < nodes; i++)
				node_at[i] = node_at[i-1] + cnt[i-1];

			for (int i = 0; i < nodes; i++) begin
				for (int j = 0; j < cnt[i]; j++) begin
					// stray write anywhere in the table
					if ($urandom_range(0, 11) == 0)
						send_arc($urandom_range(0, 4095), LTR_W'($urandom),
							$urandom_range(0, 4095), 1'($urandom), 1'($urandom));
					addr = node_at[i] + j;
					lbl = ($urandom_range(0, 99) < 80) ? LTR_W'(8'h61 + $urandom_range(0, 7))
						: LTR_W'($urandom);
					r = $urandom_range(0, 99);
					if (r < 20)
						tgt = 0;
					else if (r < 25)
						tgt = $urandom_range(0, 4095);
					else
						tgt = node_at[$urandom_range(0, nodes - 1)];
					lst = (j == cnt[i] - 1);
					// unterminated arc at the top of the table
					if (addr == 4095 && $urandom_range(0, 1) == 1)
						lst = 1'b0;
					send_arc(addr, lbl, tgt, 1'($urandom), lst);
				end
			end

			wait_quiet();
			r = $urandom_range(0, 19);
			if (r == 0)
				set_start_node(0);
			else if (r == 1)
				set_start_node(4095);
			else if (r == 2)
				set_start_node($urandom_range(0, 4095));
			else if (r < 6)
				set_start_node(node_at[$urandom_range(0, nodes - 1)]);
			else
				set_start_node(node_at[0]);

			r = $urandom_range(6, 16);
			for (int w = 0; w < r; w++)
				send_word($urandom_range(1, 6));
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall runs, quiet stretches, and requested long
	// hold-offs counted here.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : rx_stall_gen
		int n;
		if (hold_served != hold_req) begin
			hold_served = hold_req;
			hold_left   = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (rx_quiet) begin
			result_stall <= 1'b0;
		end else if (rx_run > 0) begin
			rx_run--;
		end else if (result_stall) begin
			result_stall <= 1'b0;
			rx_run = $urandom_range(0, 8);
		end else begin
			n = pick_gap();
			if (n > 0) begin
				result_stall <= 1'b1;
				rx_run = n - 1;
			end else begin
				rx_run = $urandom_range(0, 8);
			end
		end
	end

	// Result checker: every accepted result beat against the oldest verdict.
	always @(posedge clk) begin : verdict_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (verdict_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result beat: alive=%0b acc=%0b done=%0b arc=%0d",
						result.prefix_alive, result.accepted, result.word_done,
						result.arc_used);
			end else begin
				want = verdict_q.pop_front();
				if (result.prefix_alive !== want.prefix_alive
						|| result.accepted !== want.accepted
						|| result.word_done !== want.word_done
						|| result.arc_used !== want.arc_used) begin
					err_count++;
					if (err_count <= 10)
						$display({"mismatch on result %0d: want alive=%0b acc=%0b done=%0b",
							" arc=%0d, got alive=%0b acc=%0b done=%0b arc=%0d"}, n_results,
							want.prefix_alive, want.accepted, want.word_done, want.arc_used,
							result.prefix_alive, result.accepted, result.word_done,
							result.arc_used);
				end
			end
		end
	end

	// Watchdog: too long with no beat accepted on either side.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
			$display("tb_automaton_word_acceptor: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_dictionary();
		test_table_end();
		test_sentinel_start();
		test_backpressure();
		test_random_words();

		wait_quiet();
		repeat (20) @(posedge clk);
		err_count += verdict_q.size();

		$display("covered %0d arc writes (%0d gap fills) and %0d letter beats in %0d words",
			n_writes, n_patch, n_letters, n_words);
		$display("%0d words accepted, %0d died on a missing arc, %0d result beats checked",
			n_hits, n_dead, n_results);
		if (err_count == 0) begin
			$display("tb_automaton_word_acceptor: done, clean");
		end else begin
			$display("%0d errors", err_count);
			$display("tb_automaton_word_acceptor: done, errors");
		end
		$finish;
	end

endmodule
